[sv/kfs_pkg.sv]
// ----------------------------------------------------------------------------
// kfs_pkg
// shared widths, types, register indexes and jewel constants of the
// kaleidoscope fold shader
// ----------------------------------------------------------------------------
`default_nettype none

package kfs_pkg;

   // fixed point and loop limits
   localparam int FRAC_BITS       = 8;
   localparam int MAX_FOLD_PASSES = 10;
   localparam int JEWEL_COUNT     = 6;
   localparam int TABLE_JEWELS    = 6;
   localparam int JEWELS          = (JEWEL_COUNT > TABLE_JEWELS) ? TABLE_JEWELS : JEWEL_COUNT;
   localparam int ROT_SHIFT       = 14 - FRAC_BITS;
   localparam int SQRT3_HALF_Q14  = 14189;
   localparam int HIGHLIGHT_ADD   = 90;

   // port widths
   localparam int POS_W      = 10;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int MD_W       = 9;
   localparam int ROT_W      = 16;

   // datapath widths
   localparam int COORD_W = FRAC_BITS + 16;
   localparam int MUL_W   = COORD_W + 1;
   localparam int ACC_W   = 2 * MUL_W;
   localparam int PASS_W  = (MAX_FOLD_PASSES > 1) ? $clog2(MAX_FOLD_PASSES) : 1;
   localparam int JIDX_W  = (JEWELS > 1) ? $clog2(JEWELS) : 1;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [MUL_W-1:0]   mul_type;
   typedef logic signed [ACC_W-1:0]   acc_type;
   typedef logic signed [ACC_W:0]     wide_type;
   typedef logic signed [POS_W:0]     delta_type;
   typedef logic [PASS_W-1:0]         pass_type;
   typedef logic [JIDX_W-1:0]         jidx_type;
   typedef logic [RSP_DATA_W-1:0]     color_type;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COS_ROTATION    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SIN_ROTATION    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIRROR_DISTANCE = 3'd4;

   // register reset values
   localparam logic [POS_W-1:0] CENTER_X_RESET        = 10'd400;
   localparam logic [POS_W-1:0] CENTER_Y_RESET        = 10'd240;
   localparam logic [ROT_W-1:0] COS_ROTATION_RESET    = 16'd16384;
   localparam logic [ROT_W-1:0] SIN_ROTATION_RESET    = 16'd0;
   localparam logic [MD_W-1:0]  MIRROR_DISTANCE_RESET = 9'd150;

   // jewel table: center, radius in whole pixels, 8 bit color channels
   localparam int JEWEL_CX   [TABLE_JEWELS] = '{35, -70, 15, -35, 75, -15};
   localparam int JEWEL_CY   [TABLE_JEWELS] = '{55, 15, -85, -45, -20, 5};
   localparam int JEWEL_SIZE [TABLE_JEWELS] = '{30, 20, 24, 16, 19, 12};
   localparam int JEWEL_R    [TABLE_JEWELS] = '{200, 30, 40, 150, 210, 40};
   localparam int JEWEL_G    [TABLE_JEWELS] = '{30, 170, 90, 60, 170, 190};
   localparam int JEWEL_B    [TABLE_JEWELS] = '{40, 90, 210, 200, 30, 190};

   typedef struct packed {
      coord_type cx;
      coord_type cy;
      coord_type hx;
      coord_type hy;
      acc_type   r2;
      acc_type   hr2;
      color_type color;
      color_type hi_color;
   } jewel_type;

   function automatic longint one_fx();
      return longint'(1) <<< FRAC_BITS;
   endfunction

   function automatic int lift(input int c);
      return (c + HIGHLIGHT_ADD > 255) ? 255 : c + HIGHLIGHT_ADD;
   endfunction

   function automatic color_type pack565(input int r, input int g, input int b);
      return {5'(r >> 3), 6'(g >> 2), 5'(b >> 3)};
   endfunction

   function automatic jewel_type make_jewel(input int i);
      jewel_type j;
      longint    cx;
      longint    cy;
      longint    rad;
      longint    off;
      longint    hr;
      cx  = longint'(JEWEL_CX[i]) * one_fx();
      cy  = longint'(JEWEL_CY[i]) * one_fx();
      rad = longint'(JEWEL_SIZE[i]) * one_fx();
      off = (longint'(6 * JEWEL_SIZE[i]) * one_fx() + 10) / 20;
      hr  = (longint'(14 * JEWEL_SIZE[i]) * one_fx() + 20) / 40;
      j.cx       = coord_type'(cx);
      j.cy       = coord_type'(cy);
      j.hx       = coord_type'(cx - off);
      j.hy       = coord_type'(cy - off);
      j.r2       = acc_type'(rad * rad);
      j.hr2      = acc_type'(hr * hr);
      j.color    = pack565(JEWEL_R[i], JEWEL_G[i], JEWEL_B[i]);
      j.hi_color = pack565(lift(JEWEL_R[i]), lift(JEWEL_G[i]), lift(JEWEL_B[i]));
      return j;
   endfunction

   localparam jewel_type JEWEL_ROM [TABLE_JEWELS] = '{
      make_jewel(0), make_jewel(1), make_jewel(2),
      make_jewel(3), make_jewel(4), make_jewel(5)
   };

endpackage

`default_nettype wire

[sv/kfs_mul.sv]
// ----------------------------------------------------------------------------
// kfs_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
`default_nettype none

module kfs_mul (
   input  wire logic            clock,
   input  wire kfs_pkg::mul_type mul_a,
   input  wire kfs_pkg::mul_type mul_b,
   output kfs_pkg::acc_type     product
);

   kfs_pkg::acc_type product_ff;
   kfs_pkg::acc_type product_in;

   assign product_in = mul_a * mul_b;
   assign product    = product_ff;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

`default_nettype wire

[sv/kaleidoscope_fold_shader_unit.sv]
// ----------------------------------------------------------------------------
// kaleidoscope_fold_shader_unit
// sequence: rotation, fold passes over the mirrors, then the jewel and highlight
//   circle tests on the shared multiplier, then the output register
// throughput: one transaction at a time; a new one is taken only when idle
// reset: synchronous active high; registers take their defaults, unit idles
// ----------------------------------------------------------------------------
`default_nettype none

module kaleidoscope_fold_shader_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request channel
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [kfs_pkg::REQ_DATA_W-1:0]     req_tdata,  // pos_x [9:0], pos_y [19:10]
   // response channel
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [kfs_pkg::RSP_DATA_W-1:0]          rsp_tdata,  // color [15:0]
   // register write port
   input  wire logic                               csr_we,
   input  wire logic [kfs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [kfs_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // sequencer states
   typedef enum logic [10:0] {
      ST_IDLE = 11'b000_0000_0001,  // waiting for a transaction
      ST_ROT  = 11'b000_0000_0010,  // rotation, five steps on the multiplier
      ST_M0   = 11'b000_0000_0100,  // horizontal mirror, no multiply needed
      ST_MA   = 11'b000_0000_1000,  // x times sqrt3/2
      ST_MB   = 11'b000_0001_0000,  // distance beyond slanted mirror
      ST_MC   = 11'b000_0010_0000,  // distance times sqrt3/2
      ST_MD   = 11'b000_0100_0000,  // apply reflection
      ST_JA   = 11'b000_1000_0000,  // dx squared
      ST_JB   = 11'b001_0000_0000,  // dy squared
      ST_JC   = 11'b010_0000_0000,  // circle compare
      ST_DONE = 11'b100_0000_0000   // hand result to output register
   } state_type;

   localparam int RND14 = 14;
   localparam int RND13 = 13;

   // configuration registers
   logic [kfs_pkg::POS_W-1:0]  center_x_ff;
   logic [kfs_pkg::POS_W-1:0]  center_y_ff;
   logic signed [kfs_pkg::ROT_W-1:0] cos_ff;
   logic signed [kfs_pkg::ROT_W-1:0] sin_ff;
   logic [kfs_pkg::MD_W-1:0]   mirror_ff;

   // sequencer and datapath registers
   state_type           state_ff,  state_in;
   logic [2:0]          step_ff,   step_in;
   kfs_pkg::delta_type  dx_ff,     dx_in;
   kfs_pkg::delta_type  dy_ff,     dy_in;
   kfs_pkg::coord_type  x_ff,      x_in;
   kfs_pkg::coord_type  y_ff,      y_in;
   kfs_pkg::acc_type    acc_ff,    acc_in;
   kfs_pkg::mul_type    dist_ff,   dist_in;
   logic                mir_ff,    mir_in;     // 0: second mirror, 1: third mirror
   logic                moved_ff,  moved_in;
   kfs_pkg::pass_type   pass_ff,   pass_in;
   kfs_pkg::jidx_type   jidx_ff,   jidx_in;
   logic                hl_ff,     hl_in;      // testing highlight circle
   kfs_pkg::color_type  color_ff,  color_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;
   kfs_pkg::color_type  rsp_tdata_ff,  rsp_tdata_in;

   // shared multiplier
   kfs_pkg::mul_type    mul_a;
   kfs_pkg::mul_type    mul_b;
   kfs_pkg::acc_type    prod;

   // combinational helpers
   kfs_pkg::coord_type  d_fx;
   kfs_pkg::acc_type    rot_sum;
   kfs_pkg::mul_type    dist0;
   kfs_pkg::acc_type    dot_acc;
   kfs_pkg::mul_type    dist12;
   kfs_pkg::coord_type  delta;
   kfs_pkg::jewel_type  jewel;
   kfs_pkg::coord_type  jcx;
   kfs_pkg::coord_type  jcy;
   kfs_pkg::wide_type   jsum;
   kfs_pkg::wide_type   jlim;
   logic                hit;
   logic                last_pass;
   logic                out_free;
   logic                req_accept;

   kfs_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (prod)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   // mirror distance in fixed point
   assign d_fx      = kfs_pkg::coord_type'(mirror_ff) <<< kfs_pkg::FRAC_BITS;
   assign last_pass = (pass_ff == kfs_pkg::pass_type'(kfs_pkg::MAX_FOLD_PASSES - 1));

   // jewel under test and the circle selected by the highlight flag
   assign jewel = kfs_pkg::JEWEL_ROM[jidx_ff];
   assign jcx   = hl_ff ? jewel.hx : jewel.cx;
   assign jcy   = hl_ff ? jewel.hy : jewel.cy;
   assign jsum  = kfs_pkg::wide_type'(acc_ff) + kfs_pkg::wide_type'(prod);
   assign jlim  = kfs_pkg::wide_type'(hl_ff ? jewel.hr2 : jewel.r2);
   assign hit   = (jsum <= jlim);

   // rotation: second product of a pair joins the first, then rounds
   assign rot_sum = (step_ff == 3'd2) ? (acc_ff + prod) : (acc_ff - prod);

   // horizontal mirror distance
   assign dist0 = kfs_pkg::mul_type'(y_ff) - kfs_pkg::mul_type'(d_fx);

   // slanted mirror distance: (-/+ x*H - y*2^13) / 2^14, rounded, minus d
   assign dot_acc = (mir_ff ? prod : -prod) - (kfs_pkg::acc_type'(y_ff) <<< RND13);
   assign dist12  = kfs_pkg::mul_type'((dot_acc + (kfs_pkg::acc_type'(1) <<< (RND14 - 1)))
                       >>> RND14) - kfs_pkg::mul_type'(d_fx);

   // x correction: dist*H / 2^13, rounded
   assign delta = kfs_pkg::coord_type'((prod + (kfs_pkg::acc_type'(1) <<< (RND13 - 1)))
                     >>> RND13);

   // multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_ROT: begin
            case (step_ff)
               3'd0: begin
                  mul_a = kfs_pkg::mul_type'(dx_ff);
                  mul_b = kfs_pkg::mul_type'(cos_ff);
               end
               3'd1: begin
                  mul_a = kfs_pkg::mul_type'(dy_ff);
                  mul_b = kfs_pkg::mul_type'(sin_ff);
               end
               3'd2: begin
                  mul_a = kfs_pkg::mul_type'(dy_ff);
                  mul_b = kfs_pkg::mul_type'(cos_ff);
               end
               3'd3: begin
                  mul_a = kfs_pkg::mul_type'(dx_ff);
                  mul_b = kfs_pkg::mul_type'(sin_ff);
               end
               default: begin
                  mul_a = '0;
                  mul_b = '0;
               end
            endcase
         end
         ST_MA: begin
            mul_a = kfs_pkg::mul_type'(x_ff);
            mul_b = kfs_pkg::mul_type'(kfs_pkg::SQRT3_HALF_Q14);
         end
         ST_MC: begin
            mul_a = dist_ff;
            mul_b = kfs_pkg::mul_type'(kfs_pkg::SQRT3_HALF_Q14);
         end
         ST_JA: begin
            mul_a = kfs_pkg::mul_type'(x_ff) - kfs_pkg::mul_type'(jcx);
            mul_b = kfs_pkg::mul_type'(x_ff) - kfs_pkg::mul_type'(jcx);
         end
         ST_JB: begin
            mul_a = kfs_pkg::mul_type'(y_ff) - kfs_pkg::mul_type'(jcy);
            mul_b = kfs_pkg::mul_type'(y_ff) - kfs_pkg::mul_type'(jcy);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      acc_in        = acc_ff;
      dist_in       = dist_ff;
      mir_in        = mir_ff;
      moved_in      = moved_ff;
      pass_in       = pass_ff;
      jidx_in       = jidx_ff;
      hl_in         = hl_ff;
      color_in      = color_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               dx_in    = kfs_pkg::delta_type'({1'b0, req_tdata[9:0]})
                          - kfs_pkg::delta_type'({1'b0, center_x_ff});
               dy_in    = kfs_pkg::delta_type'({1'b0, req_tdata[19:10]})
                          - kfs_pkg::delta_type'({1'b0, center_y_ff});
               step_in  = 3'd0;
               state_in = ST_ROT;
            end
         end

         ST_ROT: begin
            step_in = step_ff + 3'd1;
            case (step_ff)
               3'd1, 3'd3: begin
                  acc_in = prod;
               end
               3'd2: begin
                  x_in = kfs_pkg::coord_type'((rot_sum
                         + (kfs_pkg::acc_type'(1) <<< (kfs_pkg::ROT_SHIFT - 1)))
                         >>> kfs_pkg::ROT_SHIFT);
               end
               3'd4: begin
                  y_in     = kfs_pkg::coord_type'((rot_sum
                             + (kfs_pkg::acc_type'(1) <<< (kfs_pkg::ROT_SHIFT - 1)))
                             >>> kfs_pkg::ROT_SHIFT);
                  pass_in  = '0;
                  moved_in = 1'b0;
                  state_in = ST_M0;
               end
               default: begin
                  step_in = step_ff + 3'd1;
               end
            endcase
         end

         ST_M0: begin
            if (dist0 > 0) begin
               y_in     = kfs_pkg::coord_type'(kfs_pkg::mul_type'(y_ff) - (dist0 <<< 1));
               moved_in = 1'b1;
            end
            mir_in   = 1'b0;
            state_in = ST_MA;
         end

         ST_MA: begin
            state_in = ST_MB;
         end

         ST_MB: begin
            if (dist12 > 0) begin
               dist_in  = dist12;
               state_in = ST_MC;
            end else if (!mir_ff) begin
               mir_in   = 1'b1;
               state_in = ST_MA;
            end else if (!moved_ff || last_pass) begin
               // pass without reflection, or passes used up
               jidx_in  = '0;
               hl_in    = 1'b0;
               state_in = ST_JA;
            end else begin
               pass_in  = pass_ff + 1'b1;
               moved_in = 1'b0;
               state_in = ST_M0;
            end
         end

         ST_MC: begin
            state_in = ST_MD;
         end

         ST_MD: begin
            x_in     = mir_ff ? (x_ff - delta) : (x_ff + delta);
            y_in     = y_ff + kfs_pkg::coord_type'(dist_ff);
            moved_in = 1'b1;
            if (!mir_ff) begin
               mir_in   = 1'b1;
               state_in = ST_MA;
            end else if (last_pass) begin
               jidx_in  = '0;
               hl_in    = 1'b0;
               state_in = ST_JA;
            end else begin
               pass_in  = pass_ff + 1'b1;
               moved_in = 1'b0;
               state_in = ST_M0;
            end
         end

         ST_JA: begin
            state_in = ST_JB;
         end

         ST_JB: begin
            acc_in   = prod;
            state_in = ST_JC;
         end

         ST_JC: begin
            if (hl_ff) begin
               color_in = hit ? jewel.hi_color : jewel.color;
               state_in = ST_DONE;
            end else if (hit) begin
               hl_in    = 1'b1;
               state_in = ST_JA;
            end else if (jidx_ff == kfs_pkg::jidx_type'(kfs_pkg::JEWELS - 1)) begin
               // no jewel hit: black background
               color_in = '0;
               state_in = ST_DONE;
            end else begin
               jidx_in  = jidx_ff + 1'b1;
               state_in = ST_JA;
            end
         end

         ST_DONE: begin
            // wait for the output register to drain
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = color_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      step_ff      <= step_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      acc_ff       <= acc_in;
      dist_ff      <= dist_in;
      mir_ff       <= mir_in;
      moved_ff     <= moved_in;
      pass_ff      <= pass_in;
      jidx_ff      <= jidx_in;
      hl_ff        <= hl_in;
      color_ff     <= color_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   // configuration registers, unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= kfs_pkg::CENTER_X_RESET;
         center_y_ff <= kfs_pkg::CENTER_Y_RESET;
         cos_ff      <= kfs_pkg::COS_ROTATION_RESET;
         sin_ff      <= kfs_pkg::SIN_ROTATION_RESET;
         mirror_ff   <= kfs_pkg::MIRROR_DISTANCE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            kfs_pkg::CSR_CENTER_X:        center_x_ff <= csr_wdata[kfs_pkg::POS_W-1:0];
            kfs_pkg::CSR_CENTER_Y:        center_y_ff <= csr_wdata[kfs_pkg::POS_W-1:0];
            kfs_pkg::CSR_COS_ROTATION:    cos_ff      <= csr_wdata[kfs_pkg::ROT_W-1:0];
            kfs_pkg::CSR_SIN_ROTATION:    sin_ff      <= csr_wdata[kfs_pkg::ROT_W-1:0];
            kfs_pkg::CSR_MIRROR_DISTANCE: mirror_ff   <= csr_wdata[kfs_pkg::MD_W-1:0];
            default: begin
               center_x_ff <= center_x_ff;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

[sim/kfs_shade_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfs_shade_checker
// Passive scoreboard for the kaleidoscope fold shader. It watches register
// writes and both stream channels, works out the color of every accepted
// position from its own copy of the registers and compares it with the
// results in order.
// ----------------------------------------------------------------------------

module kfs_shade_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [kfs_pkg::REQ_DATA_W-1:0]      req_tdata,   // pos_x [9:0], pos_y [19:10]
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [kfs_pkg::RSP_DATA_W-1:0]      rsp_tdata,   // color [15:0]
   input  logic                                csr_we,
   input  logic [kfs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [kfs_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output int                                  mismatches,
   output int                                  pending,
   output int                                  shaded,
   output int                                  black_hits,
   output int                                  body_hits,
   output int                                  glint_hits,
   output int                                  capped_folds
);

   import kfs_pkg::*;

   localparam longint Q14_HALF     = 8192;
   localparam int     REPORT_LIMIT = 10;

   typedef struct packed {
      logic [POS_W-1:0] px;
      logic [POS_W-1:0] py;
      color_type        color;
   } color_due_type;

   typedef struct packed {
      int cx;
      int cy;
      int size;
      int r;
      int g;
      int b;
   } gem_type;

   // private copy of the register file
   logic [POS_W-1:0]        ctr_x;
   logic [POS_W-1:0]        ctr_y;
   logic signed [ROT_W-1:0] rot_cos;
   logic signed [ROT_W-1:0] rot_sin;
   logic [MD_W-1:0]         mirror_dist;

   color_due_type colors_due [$];
   int         errors_seen  = 0;
   int         results_seen = 0;
   int         n_black      = 0;
   int         n_body       = 0;
   int         n_glint      = 0;
   int         n_capped     = 0;

   initial begin
      mismatches   = 0;
      pending      = 0;
      shaded       = 0;
      black_hits   = 0;
      body_hits    = 0;
      glint_hits   = 0;
      capped_folds = 0;
   end

   function automatic gem_type gem_at(input int i);
      case (i)
         0:       return '{35, 55, 30, 200, 30, 40};
         1:       return '{-70, 15, 20, 30, 170, 90};
         2:       return '{15, -85, 24, 40, 90, 210};
         3:       return '{-35, -45, 16, 150, 60, 200};
         4:       return '{75, -20, 19, 210, 170, 30};
         default: return '{-15, 5, 12, 40, 190, 190};
      endcase
   endfunction

   // round to nearest, halves toward plus infinity
   function automatic longint round_to(input longint v, input int s);
      if (s == 0) return v;
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic logic [7:0] glint(input int c);
      return (c + HIGHLIGHT_ADD > 255) ? 8'd255 : 8'(c + HIGHLIGHT_ADD);
   endfunction

   function automatic color_type to_rgb565(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
      return {r[7:3], g[7:2], b[7:3]};
   endfunction

   // kind: 0 background, 1 jewel body, 2 highlight
   function automatic color_type shade_position(input logic [POS_W-1:0] px,
                                                input logic [POS_W-1:0] py,
                                                output bit capped, output int kind);
      longint    dx;
      longint    dy;
      longint    x;
      longint    y;
      longint    d;
      longint    excess;
      longint    one;
      longint    jx;
      longint    jy;
      longint    rad;
      longint    off;
      longint    hrad;
      longint    ex;
      longint    ey;
      bit        moved;
      bit        found;
      gem_type   gem;
      color_type color;
      dx = longint'(px) - longint'(ctr_x);
      dy = longint'(py) - longint'(ctr_y);
      x  = round_to(dx * longint'(rot_cos) + dy * longint'(rot_sin), 14 - FRAC_BITS);
      y  = round_to(dy * longint'(rot_cos) - dx * longint'(rot_sin), 14 - FRAC_BITS);
      d  = longint'(mirror_dist) << FRAC_BITS;
      capped = 1'b0;
      for (int p = 0; p < MAX_FOLD_PASSES; p++) begin
         moved = 1'b0;
         excess = y - d;
         if (excess > 0) begin
            y = y - 2 * excess;
            moved = 1'b1;
         end
         excess = round_to(-x * SQRT3_HALF_Q14 - y * Q14_HALF, 14) - d;
         if (excess > 0) begin
            x = x + round_to(excess * SQRT3_HALF_Q14, 13);
            y = y + excess;
            moved = 1'b1;
         end
         excess = round_to(x * SQRT3_HALF_Q14 - y * Q14_HALF, 14) - d;
         if (excess > 0) begin
            x = x - round_to(excess * SQRT3_HALF_Q14, 13);
            y = y + excess;
            moved = 1'b1;
         end
         if (!moved) break;
         if (p == MAX_FOLD_PASSES - 1) capped = 1'b1;
      end
      // first jewel in table order wins
      one   = longint'(1) << FRAC_BITS;
      color = '0;
      kind  = 0;
      found = 1'b0;
      for (int i = 0; i < JEWELS; i++) begin
         gem = gem_at(i);
         jx  = longint'(gem.cx) * one;
         jy  = longint'(gem.cy) * one;
         rad = longint'(gem.size) * one;
         ex  = x - jx;
         ey  = y - jy;
         if (!found && ex * ex + ey * ey <= rad * rad) begin
            found = 1'b1;
            off   = (longint'(6 * gem.size) * one + 10) / 20;
            hrad  = (longint'(14 * gem.size) * one + 20) / 40;
            ex    = x - (jx - off);
            ey    = y - (jy - off);
            if (ex * ex + ey * ey <= hrad * hrad) begin
               color = to_rgb565(glint(gem.r), glint(gem.g), glint(gem.b));
               kind  = 2;
            end else begin
               color = to_rgb565(8'(gem.r), 8'(gem.g), 8'(gem.b));
               kind  = 1;
            end
         end
      end
      return color;
   endfunction

   always @(posedge clock) begin : watch
      color_due_type due;
      bit         capped;
      int         kind;
      if (reset) begin
         ctr_x       = CENTER_X_RESET;
         ctr_y       = CENTER_Y_RESET;
         rot_cos     = COS_ROTATION_RESET;
         rot_sin     = SIN_ROTATION_RESET;
         mirror_dist = MIRROR_DISTANCE_RESET;
         colors_due.delete();
      end else begin
         // result first: it belongs to an older transaction than any accepted now
         if (rsp_tvalid && rsp_tready) begin
            if (colors_due.size() == 0) begin
               errors_seen++;
               if (errors_seen <= REPORT_LIMIT)
                  $display("checker: color %h arrived with nothing outstanding", rsp_tdata);
            end else begin
               due = colors_due.pop_front();
               results_seen++;
               if (rsp_tdata !== due.color) begin
                  errors_seen++;
                  if (errors_seen <= REPORT_LIMIT)
                     $display("checker: color of (%0d,%0d) expected %h actual %h",
                              due.px, due.py, due.color, rsp_tdata);
               end
            end
         end
         // request uses the registers as they were before this edge
         if (req_tvalid && req_tready) begin
            due.px    = req_tdata[POS_W-1:0];
            due.py    = req_tdata[2*POS_W-1:POS_W];
            due.color = shade_position(due.px, due.py, capped, kind);
            colors_due.insert(colors_due.size(), due);
            if (capped) n_capped++;
            case (kind)
               0:       n_black++;
               1:       n_body++;
               default: n_glint++;
            endcase
         end
         if (csr_we) begin
            case (csr_index)
               CSR_CENTER_X:        ctr_x       = csr_wdata[POS_W-1:0];
               CSR_CENTER_Y:        ctr_y       = csr_wdata[POS_W-1:0];
               CSR_COS_ROTATION:    rot_cos     = csr_wdata[ROT_W-1:0];
               CSR_SIN_ROTATION:    rot_sin     = csr_wdata[ROT_W-1:0];
               CSR_MIRROR_DISTANCE: mirror_dist = csr_wdata[MD_W-1:0];
               default: ;
            endcase
         end
      end
      mismatches   <= errors_seen;
      pending      <= colors_due.size();
      shaded       <= results_seen;
      black_hits   <= n_black;
      body_hits    <= n_body;
      glint_hits   <= n_glint;
      capped_folds <= n_capped;
   end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus top for the kaleidoscope fold shader unit. A directed opening hits
// the corners, jewel body and highlight, reflections, out-of-range rotation,
// zero and maximum mirror distance and unused register indexes; random
// register settings then follow, each with a burst of positions mostly
// clustered around the center. Both streams idle in random bursts except in
// the final setting. Checking lives in kfs_shade_checker.
// ----------------------------------------------------------------------------

module tb;

   import kfs_pkg::*;

   localparam int RANDOM_SETTINGS   = 12;
   localparam int ITEMS_PER_SETTING = 150;
   localparam int STALL_LIMIT       = 4000;  // cycles without any transaction
   localparam int TAIL_CYCLES       = 200;   // beyond the worst-case latency

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // pos_x [9:0], pos_y [19:10]
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // color [15:0]
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // scoreboard status
   int mismatches;
   int pending;
   int shaded;
   int black_hits;
   int body_hits;
   int glint_hits;
   int capped_folds;

   // idling knobs in percent, changed per register setting
   int gap_pct   = 0;
   int stall_pct = 0;

   // register values in force, used to aim positions at the kaleidoscope
   int cur_cx = 400;
   int cur_cy = 240;
   int cur_md = 150;
   int settings    = 1;
   int junk_writes = 0;
   int quiet_cycles = 0;

   kaleidoscope_fold_shader_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   kfs_shade_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .mismatches   (mismatches),
      .pending      (pending),
      .shaded       (shaded),
      .black_hits   (black_hits),
      .body_hits    (body_hits),
      .glint_hits   (glint_hits),
      .capped_folds (capped_folds)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // response side: ready drops in bursts drawn with the stall_pct odds
   initial begin
      rsp_tready <= 1'b1;
      forever begin
         @(posedge clock);
         if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog: a hung block shows up as a long stretch with no transaction
   always @(posedge clock) begin
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: no transaction for %0d cycles, %0d colors outstanding",
                     quiet_cycles, pending);
            $display("tb: done, errors");
            $finish;
         end
      end
   end

   // one position transaction; valid stays high into the next one unless a gap is drawn
   task automatic send_position(input int px, input int py);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W - 2 * POS_W){1'b0}}, POS_W'(py), POS_W'(px)};
      do @(posedge clock); while (!req_tready);
   endtask

   // wait until every color has come back and the unit is idle again
   task automatic settle();
      @(posedge clock);
      wait (pending == 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic put_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // full register set, back to back, plus one write to an unused index;
   // spare upper bits carry garbage that the unit has to drop
   task automatic program_registers(input int cx, input int cy, input int rc, input int rs,
                                    input int md);
      put_reg(CSR_CENTER_X,        {6'($urandom), 10'(cx)});
      put_reg(CSR_CENTER_Y,        {6'($urandom), 10'(cy)});
      put_reg(CSR_COS_ROTATION,    16'(rc));
      put_reg(CSR_SIN_ROTATION,    16'(rs));
      put_reg(CSR_MIRROR_DISTANCE, {7'($urandom), 9'(md)});
      put_reg(CSR_IDX_W'($urandom_range(int'(CSR_MIRROR_DISTANCE) + 1, (1 << CSR_IDX_W) - 1)),
              16'($urandom));
      csr_we <= 1'b0;
      cur_cx = cx;
      cur_cy = cy;
      cur_md = md;
      settings++;
      junk_writes++;
   endtask

   initial begin : stimulus
      int cx;
      int cy;
      int rc;
      int rs;
      int md;
      int px;
      int py;
      int span;
      bit calm;

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // registers at their reset values: corners, origin, jewel body and
      // highlight, one point past the top mirror, alternating bit patterns
      send_position(0, 0);
      send_position(1023, 1023);
      send_position(0, 1023);
      send_position(1023, 0);
      send_position(400, 240);
      send_position(435, 295);
      send_position(426, 286);
      send_position(400, 440);
      send_position(10'h2AA, 10'h155);
      send_position(10'h155, 10'h2AA);
      req_tvalid <= 1'b0;
      settle();

      // rotation beyond unit length and zero mirror distance, so the fold
      // runs out of passes
      program_registers(1023, 0, -32768, 32767, 0);
      send_position(0, 0);
      send_position(1023, 1023);
      send_position(512, 512);
      send_position(1000, 20);
      req_tvalid <= 1'b0;
      settle();

      // widest mirror distance, rotated by a quarter turn
      program_registers(0, 1023, 0, -16384, 511);
      send_position(0, 1023);
      send_position(0, 0);
      send_position(511, 768);
      req_tvalid <= 1'b0;
      settle();

      // narrowest legal mirror distance, eighth turn
      program_registers(512, 512, 11585, 11585, 1);
      send_position(512, 512);
      send_position(600, 420);
      send_position(300, 700);
      req_tvalid <= 1'b0;
      settle();

      // random settings, each followed by a burst of positions
      for (int ph = 0; ph < RANDOM_SETTINGS; ph++) begin
         calm = (ph == RANDOM_SETTINGS - 1);
         case ($urandom_range(0, 3))
            0:       gap_pct = 0;
            1:       gap_pct = 10;
            2:       gap_pct = 25;
            default: gap_pct = 50;
         endcase
         case ($urandom_range(0, 3))
            0:       stall_pct = 0;
            1:       stall_pct = 10;
            2:       stall_pct = 25;
            default: stall_pct = 50;
         endcase
         if (calm) begin
            gap_pct   = 0;
            stall_pct = 0;
         end

         if ($urandom_range(0, 5) == 0) begin
            cx = $urandom_range(0, 1) ? 1023 : 0;
            cy = $urandom_range(0, 1) ? 1023 : 0;
         end else begin
            cx = $urandom_range(0, 1023);
            cy = $urandom_range(0, 1023);
         end

         // mostly unit rotations, sometimes any length within range or any code
         case ($urandom_range(0, 3))
            0, 1: begin
               case ($urandom_range(0, 7))
                  0:       begin rc = 16384;  rs = 0;      end
                  1:       begin rc = 14189;  rs = 8192;   end
                  2:       begin rc = 8192;   rs = 14189;  end
                  3:       begin rc = 0;      rs = 16384;  end
                  4:       begin rc = 11585;  rs = 11585;  end
                  5:       begin rc = -16384; rs = 0;      end
                  6:       begin rc = -8192;  rs = -14189; end
                  default: begin rc = 14189;  rs = -8192;  end
               endcase
            end
            2: begin
               rc = int'($urandom_range(0, 32768)) - 16384;
               rs = int'($urandom_range(0, 32768)) - 16384;
            end
            default: begin
               rc = int'($signed(16'($urandom)));
               rs = int'($signed(16'($urandom)));
            end
         endcase

         case ($urandom_range(0, 3))
            0:    md = $urandom_range(1, 511);
            1, 2: md = $urandom_range(60, 200);
            default: begin
               case ($urandom_range(0, 2))
                  0:       md = 0;
                  1:       md = 1;
                  default: md = 511;
               endcase
            end
         endcase

         program_registers(cx, cy, rc, rs, md);

         // most positions land inside a few mirror distances of the center,
         // where folding and the jewels matter
         span = cur_md * 2 + 40;
         for (int k = 0; k < ITEMS_PER_SETTING; k++) begin
            if ($urandom_range(0, 4) != 0) begin
               px = cur_cx + int'($urandom_range(0, 2 * span)) - span;
               py = cur_cy + int'($urandom_range(0, 2 * span)) - span;
               px = (px < 0) ? 0 : ((px > 1023) ? 1023 : px);
               py = (py < 0) ? 0 : ((py > 1023) ? 1023 : py);
            end else begin
               px = $urandom_range(0, 1023);
               py = $urandom_range(0, 1023);
            end
            send_position(px, py);
         end
         req_tvalid <= 1'b0;
         settle();
      end

      // nothing outstanding now; leave room for a stray late result
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("tb: %0d colors checked over %0d register settings, %0d unused-index writes",
               shaded, settings, junk_writes);
      $display("tb: %0d background, %0d jewel body, %0d highlight, %0d out of fold passes",
               black_hits, body_hits, glint_hits, capped_folds);
      if (mismatches == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

[kaleidoscope_fold_shader_unit.f]
sv/kfs_pkg.sv
sv/kfs_mul.sv
sv/kaleidoscope_fold_shader_unit.sv
sim/kfs_shade_checker.sv
sim/tb.sv
